// ===== design/cfpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpp_pkg: shared types and constants of the pixel plotter
// Operation codes, register indexes, item structs and default geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package cfpp_pkg;

    // Default panel geometry.
    localparam int VISIBLE_COLUMNS_DEF = 792;
    localparam int DRIVER_COLUMNS_DEF  = 800;
    localparam int PANEL_ROWS_DEF      = 272;
    localparam int SEAM_COLUMN_DEF     = 396;
    localparam int SEAM_GAP_DEF        = 8;
    localparam int FRAME_BYTES_DEF     = (DRIVER_COLUMNS_DEF / 8) * PANEL_ROWS_DEF;

    // Driver coordinates stay below 4096, and a byte address below 2**22.
    localparam int CW = 12;
    localparam int AW = 22;

    localparam logic [7:0] BYTE_WHITE = 8'hFF;
    localparam logic [7:0] MASK_MSB   = 8'h80;

    typedef logic [1:0] t_op;
    localparam t_op OP_PLOT  = 2'd0;
    localparam t_op OP_CLEAR = 2'd1;
    localparam t_op OP_READ  = 2'd2;

    typedef logic [1:0] t_reg_index;
    localparam t_reg_index REG_CLIP_LEFT   = 2'd0;
    localparam t_reg_index REG_CLIP_TOP    = 2'd1;
    localparam t_reg_index REG_CLIP_RIGHT  = 2'd2;
    localparam t_reg_index REG_CLIP_BOTTOM = 2'd3;

    typedef struct packed {
        t_op                operation;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic        [15:0] colour;
        logic        [14:0] read_address;
    } t_in_item;

    typedef struct packed {
        logic        written;
        logic [14:0] byte_address;
        logic [7:0]  byte_value;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/cfpp_ifs.sv =====
// ----------------------------------------------------------------------------
// cfpp_ifs: channel interfaces of the pixel plotter
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfpp_in_if import cfpp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface cfpp_out_if import cfpp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface cfpp_cfg_if import cfpp_pkg::*; ();
    logic        valid;
    logic        ready;
    t_reg_index  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/cfpp_frame_ram.sv =====
// ----------------------------------------------------------------------------
// cfpp_frame_ram: frame buffer byte memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpp_frame_ram import cfpp_pkg::*; #(
    parameter int DEPTH  = FRAME_BYTES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [7:0]        i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output      logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read, so a stalled consumer keeps it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/clipped_framebuffer_pixel_plotter_core.sv =====
// ----------------------------------------------------------------------------
// clipped_framebuffer_pixel_plotter_core: 1-bit-per-pixel frame buffer plotter
// Clips, maps and plots pixels into a byte memory; clears it and reads it out.
// ----------------------------------------------------------------------------
// Plot and read items flow through a three-step pipeline (decode, memory read,
// modify and write back) and are taken one per cycle unless the output stalls
// or a clearing pass runs. An item moves in turn through the decode, write-back
// and output registers. The frame buffer is a single synchronous byte memory
// with one write and one read port, and consecutive plots to the same byte are
// forwarded from the write-back step, so no bubbles are needed. A clear item
// walks the memory one byte per cycle, and its result appears once that pass
// has finished; the same clearing pass runs after reset. While a pass runs, no
// new item is taken, but configuration writes are. Dropped plots, clears, reads
// beyond the store and unused operation codes each still return one result.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_framebuffer_pixel_plotter_core import cfpp_pkg::*; #(
    parameter int VISIBLE_COLUMNS = VISIBLE_COLUMNS_DEF,
    parameter int DRIVER_COLUMNS  = DRIVER_COLUMNS_DEF,
    parameter int PANEL_ROWS      = PANEL_ROWS_DEF,
    parameter int SEAM_COLUMN     = SEAM_COLUMN_DEF,
    parameter int SEAM_GAP        = SEAM_GAP_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cfpp_in_if.sink   i_in,
    cfpp_out_if.source o_out,
    cfpp_cfg_if.sink  i_cfg
);

    localparam int ROW_BYTES   = DRIVER_COLUMNS / 8;
    localparam int FRAME_BYTES = ROW_BYTES * PANEL_ROWS;
    localparam int MAW         = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    localparam logic [14:0]    VIS_COLS_C  = 15'(VISIBLE_COLUMNS);
    localparam logic [14:0]    ROWS_C      = 15'(PANEL_ROWS);
    localparam logic [14:0]    SEAM_C      = 15'(SEAM_COLUMN);
    localparam logic [14:0]    GAP_C       = 15'(SEAM_GAP);
    localparam logic [15:0]    DRV_COLS_16 = 16'(DRIVER_COLUMNS);
    localparam logic [15:0]    ROWS_16     = 16'(PANEL_ROWS);
    localparam logic [AW-1:0]  ROW_BYTES_C = AW'(ROW_BYTES);
    localparam logic [AW-1:0]  FRAME_C     = AW'(FRAME_BYTES);
    localparam logic [MAW-1:0] LAST_BYTE   = MAW'(FRAME_BYTES - 1);

    // The controller either runs items or sweeps the memory to white.
    typedef enum logic [1:0] {
        ST_SWEEP = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    // ------------------------------------------------------------------
    // Clip registers. The configuration port never stalls.
    // ------------------------------------------------------------------
    logic signed [15:0] r_clip_left;
    logic signed [15:0] r_clip_top;
    logic signed [15:0] r_clip_right;
    logic signed [15:0] r_clip_bottom;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_left   <= 16'sd0;
            r_clip_top    <= 16'sd0;
            r_clip_right  <= 16'sd792;
            r_clip_bottom <= 16'sd272;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_CLIP_LEFT:   r_clip_left   <= i_cfg.data;
                REG_CLIP_TOP:    r_clip_top    <= i_cfg.data;
                REG_CLIP_RIGHT:  r_clip_right  <= i_cfg.data;
                REG_CLIP_BOTTOM: r_clip_bottom <= i_cfg.data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control signals.
    // ------------------------------------------------------------------
    t_state         r_state, n_state;
    logic [MAW-1:0] r_cursor, n_cursor;

    logic           r_a_valid;
    logic           r_b_valid;
    logic           r_out_valid;
    t_out_item      r_out_item;

    logic           a_go;
    logic           b_go;
    logic           in_take;

    // ------------------------------------------------------------------
    // Decode at acceptance: clip test and mapping into driver space.
    // ------------------------------------------------------------------
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic [14:0]        ux;
    logic [14:0]        uy;
    logic [14:0]        sx;
    logic [15:0]        dx16;
    logic [15:0]        dy16;
    logic               in_inside;

    always_comb begin
        in_x = i_in.item.pos_x;
        in_y = i_in.item.pos_y;
        ux   = in_x[14:0];
        uy   = in_y[14:0];
        in_inside = (in_x >= r_clip_left) && (in_y >= r_clip_top) &&
                    (in_x < r_clip_right) && (in_y < r_clip_bottom) &&
                    !in_x[15] && !in_y[15] &&
                    (ux < VIS_COLS_C) && (uy < ROWS_C);
        // Columns at or past the seam skip the gap between the two controllers.
        sx   = (ux < SEAM_C) ? ux : (ux + GAP_C);
        // Both axes are mirrored; a negative column is dropped later.
        dx16 = DRV_COLS_16 - {1'b0, sx} - 16'd1;
        dy16 = ROWS_16 - {1'b0, uy} - 16'd1;
    end

    assign in_take    = (r_state == ST_RUN) && (!r_a_valid || a_go);
    assign i_in.ready = in_take;

    t_op            r_a_op;
    logic           r_a_inside;
    logic [CW-1:0]  r_a_dx;
    logic [CW-1:0]  r_a_dy;
    logic           r_a_black;
    logic [14:0]    r_a_raddr;

    always_ff @(posedge i_clk) begin
        if (in_take && i_in.valid) begin
            r_a_op     <= i_in.item.operation;
            r_a_inside <= in_inside && !dx16[15];
            r_a_dx     <= dx16[CW-1:0];
            r_a_dy     <= dy16[CW-1:0];
            r_a_black  <= (i_in.item.colour == 16'd1);
            r_a_raddr  <= i_in.item.read_address;
        end
    end

    // ------------------------------------------------------------------
    // Address step: byte address and bit mask, memory read issue.
    // ------------------------------------------------------------------
    logic [AW-1:0] a_plot_addr;
    logic [AW-1:0] a_read_addr;
    logic [AW-1:0] a_addr;
    logic          a_hit;
    logic [7:0]    a_mask;

    always_comb begin
        a_plot_addr = AW'(r_a_dy) * ROW_BYTES_C + AW'(r_a_dx[CW-1:3]);
        a_read_addr = AW'(r_a_raddr);
        a_mask      = MASK_MSB >> r_a_dx[2:0];
        unique case (r_a_op)
            OP_PLOT: begin
                a_addr = a_plot_addr;
                a_hit  = r_a_inside && (a_plot_addr < FRAME_C);
            end
            OP_READ: begin
                a_addr = a_read_addr;
                a_hit  = (a_read_addr < FRAME_C);
            end
            default: begin
                a_addr = a_read_addr;
                a_hit  = 1'b0;
            end
        endcase
    end

    assign a_go = r_a_valid && (!r_b_valid || b_go);

    // ------------------------------------------------------------------
    // Write-back step: merge the bit, forward, and form the result.
    // ------------------------------------------------------------------
    t_op           r_b_op;
    logic          r_b_hit;
    logic [AW-1:0] r_b_addr;
    logic [7:0]    r_b_mask;
    logic          r_b_black;
    logic          r_b_fwd;
    logic [7:0]    r_b_fwd_data;
    logic          r_b_swept;

    logic [7:0]    rd_data;
    logic [7:0]    b_old;
    logic [7:0]    b_new;
    logic          b_wr;
    t_out_item     b_result;

    always_comb begin
        b_old = r_b_fwd ? r_b_fwd_data : rd_data;
        b_new = r_b_black ? (b_old & ~r_b_mask) : (b_old | r_b_mask);
        b_result = '0;
        unique case (r_b_op)
            OP_PLOT: begin
                if (r_b_hit) begin
                    b_result.written      = 1'b1;
                    b_result.byte_address = r_b_addr[14:0];
                    b_result.byte_value   = b_new;
                end
            end
            OP_CLEAR: begin
                b_result.byte_value = BYTE_WHITE;
            end
            OP_READ: begin
                b_result.byte_address = r_b_addr[14:0];
                b_result.byte_value   = r_b_hit ? b_old : 8'h00;
            end
            default: begin
                b_result = '0;
            end
        endcase
    end

    // A clear item leaves only once its sweep has finished.
    assign b_go = r_b_valid && ((r_b_op != OP_CLEAR) || r_b_swept) &&
                  (!r_out_valid || o_out.ready);
    assign b_wr = b_go && (r_b_op == OP_PLOT) && r_b_hit;

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_b_op       <= r_a_op;
            r_b_hit      <= a_hit;
            r_b_addr     <= a_addr;
            r_b_mask     <= a_mask;
            r_b_black    <= r_a_black;
            // The byte read at this edge misses a write landing at the same edge.
            r_b_fwd      <= b_wr && (a_addr == r_b_addr);
            r_b_fwd_data <= b_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_out_item <= b_result;
        end
    end

    // ------------------------------------------------------------------
    // Valid flags, clearing pass and controller state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        unique case (r_state)
            ST_SWEEP: begin
                if (r_cursor == LAST_BYTE) begin
                    n_state  = ST_RUN;
                    n_cursor = '0;
                end else begin
                    n_cursor = r_cursor + MAW'(1);
                end
            end
            ST_RUN: begin
                if (r_b_valid && (r_b_op == OP_CLEAR) && !r_b_swept) begin
                    n_state = ST_SWEEP;
                end
            end
            default: begin
                n_state  = ST_SWEEP;
                n_cursor = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_cursor    <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_b_swept   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;

            if (in_take) begin
                r_a_valid <= i_in.valid;
            end else if (a_go) begin
                r_a_valid <= 1'b0;
            end

            if (a_go) begin
                r_b_valid <= 1'b1;
                r_b_swept <= 1'b0;
            end else begin
                if (b_go) begin
                    r_b_valid <= 1'b0;
                end
                if ((r_state == ST_SWEEP) && (r_cursor == LAST_BYTE)) begin
                    r_b_swept <= 1'b1;
                end
            end

            if (b_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

    // ------------------------------------------------------------------
    // Frame memory. The sweep and the plot write-back never coincide.
    // ------------------------------------------------------------------
    logic           ram_wr_en;
    logic [MAW-1:0] ram_wr_addr;
    logic [7:0]     ram_wr_data;

    always_comb begin
        if (r_state == ST_SWEEP) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_cursor;
            ram_wr_data = BYTE_WHITE;
        end else begin
            ram_wr_en   = b_wr;
            ram_wr_addr = r_b_addr[MAW-1:0];
            ram_wr_data = b_new;
        end
    end

    cfpp_frame_ram #(
        .DEPTH  (FRAME_BYTES),
        .ADDR_W (MAW)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (a_go),
        .i_rd_addr (a_addr[MAW-1:0]),
        .o_rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_take_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> !(i_in.valid && i_in.ready))
        else $error("item accepted during clearing pass");

    a_clear_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_go && (r_b_op == OP_CLEAR)) |-> r_b_swept)
        else $error("clear result released before its sweep finished");

    a_forward_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_go && b_wr && (a_addr == r_b_addr)) |=> r_b_fwd)
        else $error("same-byte write was not forwarded");

    a_cursor_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_cursor == '0))
        else $error("sweep cursor not at zero outside a clearing pass");

    a_no_wr_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> !b_wr)
        else $error("plot write-back during clearing pass");

endmodule

`default_nettype wire
